// ===== sv/qkvag_pkg.sv =====
// Package for the QKV head tile address generator.
// Holds the geometry constants, register indexes, phase encoding and the
// structs shared by the register file, the counter core and the top level.
package qkvag_pkg;

   // Tile geometry
   localparam int SEQ_TILE_ROWS    = 16;
   localparam int HEAD_WIDTH_TILES = 2;
   localparam int HEAD_STRIDE      = 32;
   localparam int Q_HEADS          = 16;
   localparam int KV_HEADS         = 16;
   localparam int TILE_BYTES       = 2048;

   // Counter and field widths
   localparam int ADDR_W   = 32;
   localparam int OFFSET_W = 20;
   localparam int COUNT_W  = 16;
   localparam int ROW_W    = 10;
   localparam int HEAD_W   = 6;
   localparam int WIDTH_W  = 4;
   localparam int INDEX_W  = 3;

   // Steps at a block end (next row or batch rollover), per head and per tile
   localparam logic [ADDR_W-1:0] ROW_STEP     = ADDR_W'(HEAD_WIDTH_TILES);
   localparam logic [ADDR_W-1:0] Q_ROLL_STEP  =
      ADDR_W'((Q_HEADS - 1) * HEAD_STRIDE + HEAD_WIDTH_TILES);
   localparam logic [ADDR_W-1:0] KV_ROLL_STEP =
      ADDR_W'((KV_HEADS - 1) * HEAD_STRIDE + HEAD_WIDTH_TILES);
   localparam logic [ADDR_W-1:0] STRIDE_STEP  = ADDR_W'(HEAD_STRIDE);
   localparam logic [OFFSET_W-1:0] TILE_STEP  = OFFSET_W'(TILE_BYTES);

   // Register indexes
   localparam logic [INDEX_W-1:0] CSR_Q_BASE_ADDRESS = 3'd0;
   localparam logic [INDEX_W-1:0] CSR_K_BASE_ADDRESS = 3'd1;
   localparam logic [INDEX_W-1:0] CSR_V_BASE_ADDRESS = 3'd2;
   localparam logic [INDEX_W-1:0] CSR_BLOCK_COUNT    = 3'd3;
   localparam logic [INDEX_W-1:0] CSR_START_ROW      = 3'd4;
   localparam logic [INDEX_W-1:0] CSR_Q_START_PAGE   = 3'd5;
   localparam logic [INDEX_W-1:0] CSR_K_START_PAGE   = 3'd6;
   localparam logic [INDEX_W-1:0] CSR_V_START_PAGE   = 3'd7;

   typedef enum logic [1:0] {
      PHASE_Q = 2'd0,
      PHASE_K = 2'd1,
      PHASE_V = 2'd2
   } phase_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  q_base_address;
      logic [ADDR_W-1:0]  k_base_address;
      logic [ADDR_W-1:0]  v_base_address;
      logic [COUNT_W-1:0] block_count;
      logic [ROW_W-1:0]   start_row;
      logic [ADDR_W-1:0]  q_start_page;
      logic [ADDR_W-1:0]  k_start_page;
      logic [ADDR_W-1:0]  v_start_page;
   } cfg_type;

   typedef struct packed {
      logic                write_valid;
      logic [1:0]          target_tensor;
      logic [ADDR_W-1:0]   target_base;
      logic [OFFSET_W-1:0] local_offset;
      logic [ADDR_W-1:0]   dest_page;
      logic                chunk_end;
      logic                block_end;
      logic                all_done;
   } rsp_type;

endpackage

// ===== sv/qkv_head_tile_address_generator.sv =====
// Top level of the QKV head tile address generator.
// Depends on qkvag_pkg, qkvag_csr and qkvag_core.
//
// Usage:
//  - Request channel (req_valid / req_stall / req_restart): one word per tile
//    that is ready in the local buffer. req_restart reloads the walk from the
//    registers before that tile.
//  - Response channel (rsp_valid / rsp_stall / rsp_*): exactly one word per
//    request word: a write command, or write_valid low with all_done high once
//    every configured block has been issued.
//  - Register port (csr_write_enable / csr_index / csr_write_data): writes
//    are registered; bases and block count are read live, the rest at reload.
// Timing:
//  - A word passes through an input register, then the counter core feeding
//    the result register.
//  - Throughput is one word per cycle when rsp_stall is low; the counter core
//    updates with adds and compares only, so each tile finishes in the cycle it
//    leaves the input register.
//  - A stall on rsp_stall holds the result register; the input register then
//    holds one more word and req_stall rises only while both are full.
// Reset: registers clear to zero, both stages empty, and the first tile
// after reset reloads the walk as if req_restart were set.
module qkv_head_tile_address_generator
   import qkvag_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 csr_write_enable,
   input  logic [INDEX_W-1:0]   csr_index,
   input  logic [ADDR_W-1:0]    csr_write_data,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_restart,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_write_valid,
   output logic [1:0]           rsp_target_tensor,
   output logic [ADDR_W-1:0]    rsp_target_base,
   output logic [OFFSET_W-1:0]  rsp_local_offset,
   output logic [ADDR_W-1:0]    rsp_dest_page,
   output logic                 rsp_chunk_end,
   output logic                 rsp_block_end,
   output logic                 rsp_all_done
);

   cfg_type cfg;
   rsp_type core_rsp;
   rsp_type rsp_ff;

   logic in_valid_ff, in_valid_in;
   logic in_restart_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic advance;
   logic req_accept;

   qkvag_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // Walk advances exactly when the input word moves into the result register
   qkvag_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .fire    (advance),
      .restart (in_restart_ff),
      .rsp     (core_rsp)
   );

   // Result register is free when empty or being drained this cycle
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: load on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_restart_ff <= req_restart;
      end
      if (advance) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_valid   = rsp_ff.write_valid;
   assign rsp_target_tensor = rsp_ff.target_tensor;
   assign rsp_target_base   = rsp_ff.target_base;
   assign rsp_local_offset  = rsp_ff.local_offset;
   assign rsp_dest_page     = rsp_ff.dest_page;
   assign rsp_chunk_end     = rsp_ff.chunk_end;
   assign rsp_block_end     = rsp_ff.block_end;
   assign rsp_all_done      = rsp_ff.all_done;

endmodule

// ===== sv/qkvag_csr.sv =====
// Configuration register file of the QKV head tile address generator.
// Depends on qkvag_pkg for the register indexes and the cfg_type struct.
module qkvag_csr
   import qkvag_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [INDEX_W-1:0]   csr_index,
   input  logic [ADDR_W-1:0]    csr_write_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_Q_BASE_ADDRESS: cfg_in.q_base_address = csr_write_data;
            CSR_K_BASE_ADDRESS: cfg_in.k_base_address = csr_write_data;
            CSR_V_BASE_ADDRESS: cfg_in.v_base_address = csr_write_data;
            CSR_BLOCK_COUNT:    cfg_in.block_count    = csr_write_data[COUNT_W-1:0];
            CSR_START_ROW:      cfg_in.start_row      = csr_write_data[ROW_W-1:0];
            CSR_Q_START_PAGE:   cfg_in.q_start_page   = csr_write_data;
            CSR_K_START_PAGE:   cfg_in.k_start_page   = csr_write_data;
            CSR_V_START_PAGE:   cfg_in.v_start_page   = csr_write_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/qkvag_core.sv =====
// Counter core of the QKV head tile address generator: walk state and the
// combinational command for the current tile. Depends on qkvag_pkg.
module qkvag_core
   import qkvag_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    fire,
   input  logic    restart,
   output rsp_type rsp
);

   phase_type           phase_ff, phase_in, cur_phase;
   logic [HEAD_W-1:0]   head_ff, head_in, cur_head;
   logic [WIDTH_W-1:0]  width_ff, width_in, cur_width;
   logic [OFFSET_W-1:0] offset_ff, offset_in, cur_offset;
   logic [ADDR_W-1:0]   row_page_ff, row_page_in, cur_row_page;
   logic [COUNT_W-1:0]  blocks_ff, blocks_in, cur_blocks;
   logic [ROW_W-1:0]    row_ff, row_in, cur_row;
   logic [ADDR_W-1:0]   q_page_ff, q_page_in, cur_q_page;
   logic [ADDR_W-1:0]   k_page_ff, k_page_in, cur_k_page;
   logic [ADDR_W-1:0]   v_page_ff, v_page_in, cur_v_page;
   logic                load_pending_ff;

   logic                load;
   logic                done;
   logic                last_w;
   logic                chunk_end;
   logic                block_end;
   logic [HEAD_W:0]     heads;
   logic [ROW_W:0]      next_row;

   assign load = restart || load_pending_ff;

   // Reload from the registers, or continue from the stored walk
   always_comb begin
      if (load) begin
         cur_phase    = PHASE_Q;
         cur_head     = '0;
         cur_width    = '0;
         cur_offset   = '0;
         cur_blocks   = '0;
         cur_row      = cfg.start_row;
         cur_q_page   = cfg.q_start_page;
         cur_k_page   = cfg.k_start_page;
         cur_v_page   = cfg.v_start_page;
         cur_row_page = cfg.q_start_page;
      end else begin
         cur_phase    = phase_ff;
         cur_head     = head_ff;
         cur_width    = width_ff;
         cur_offset   = offset_ff;
         cur_blocks   = blocks_ff;
         cur_row      = row_ff;
         cur_q_page   = q_page_ff;
         cur_k_page   = k_page_ff;
         cur_v_page   = v_page_ff;
         cur_row_page = row_page_ff;
      end
   end

   assign done      = cur_blocks >= cfg.block_count;
   assign heads     = (cur_phase == PHASE_Q) ? (HEAD_W+1)'(Q_HEADS) : (HEAD_W+1)'(KV_HEADS);
   assign last_w    = ({1'b0, cur_width} + 1'b1) >= (WIDTH_W+1)'(HEAD_WIDTH_TILES);
   assign chunk_end = last_w && (({1'b0, cur_head} + 1'b1) >= heads);
   assign block_end = chunk_end && (cur_phase == PHASE_V);
   assign next_row  = {1'b0, cur_row} + 1'b1;

   // Command for this tile
   always_comb begin
      rsp = '0;
      if (done) begin
         rsp.all_done = 1'b1;
      end else begin
         rsp.write_valid   = 1'b1;
         rsp.target_tensor = cur_phase;
         case (cur_phase)
            PHASE_Q: rsp.target_base = cfg.q_base_address;
            PHASE_K: rsp.target_base = cfg.k_base_address;
            default: rsp.target_base = cfg.v_base_address;
         endcase
         rsp.local_offset = cur_offset;
         rsp.dest_page    = cur_row_page + ADDR_W'(cur_width);
         rsp.chunk_end    = chunk_end;
         rsp.block_end    = block_end;
         rsp.all_done     = block_end &&
                            (({1'b0, cur_blocks} + 1'b1) >= {1'b0, cfg.block_count});
      end
   end

   // Next walk state
   always_comb begin
      phase_in    = cur_phase;
      head_in     = cur_head;
      width_in    = cur_width;
      offset_in   = cur_offset;
      row_page_in = cur_row_page;
      blocks_in   = cur_blocks;
      row_in      = cur_row;
      q_page_in   = cur_q_page;
      k_page_in   = cur_k_page;
      v_page_in   = cur_v_page;
      if (!done) begin
         offset_in = cur_offset + TILE_STEP;
         width_in  = cur_width + 1'b1;
         if (last_w) begin
            width_in    = '0;
            head_in     = cur_head + 1'b1;
            row_page_in = cur_row_page + STRIDE_STEP;
         end
         if (chunk_end) begin
            head_in   = '0;
            offset_in = '0;
            case (cur_phase)
               PHASE_Q: begin
                  phase_in    = PHASE_K;
                  row_page_in = cur_k_page;
               end
               PHASE_K: begin
                  phase_in    = PHASE_V;
                  row_page_in = cur_v_page;
               end
               default: begin
                  // End of block: advance a row or roll into the next batch
                  phase_in  = PHASE_Q;
                  blocks_in = cur_blocks + 1'b1;
                  if (next_row < (ROW_W+1)'(SEQ_TILE_ROWS)) begin
                     q_page_in = cur_q_page + ROW_STEP;
                     k_page_in = cur_k_page + ROW_STEP;
                     v_page_in = cur_v_page + ROW_STEP;
                     row_in    = next_row[ROW_W-1:0];
                  end else begin
                     q_page_in = cur_q_page + Q_ROLL_STEP;
                     k_page_in = cur_k_page + KV_ROLL_STEP;
                     v_page_in = cur_v_page + KV_ROLL_STEP;
                     row_in    = '0;
                  end
                  row_page_in = q_page_in;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_pending_ff <= 1'b1;
         phase_ff        <= PHASE_Q;
         head_ff         <= '0;
         width_ff        <= '0;
         offset_ff       <= '0;
         row_page_ff     <= '0;
         blocks_ff       <= '0;
         row_ff          <= '0;
         q_page_ff       <= '0;
         k_page_ff       <= '0;
         v_page_ff       <= '0;
      end else if (fire) begin
         load_pending_ff <= 1'b0;
         phase_ff        <= phase_in;
         head_ff         <= head_in;
         width_ff        <= width_in;
         offset_ff       <= offset_in;
         row_page_ff     <= row_page_in;
         blocks_ff       <= blocks_in;
         row_ff          <= row_in;
         q_page_ff       <= q_page_in;
         k_page_ff       <= k_page_in;
         v_page_ff       <= v_page_in;
      end
   end

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for qkv_head_tile_address_generator.
// Depends on qkvag_pkg and the generator RTL; predicts every write command in
// the testbench and compares it against the response channel word by word.
module tb_top;
   import qkvag_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Cycles with no handshake on either channel before the run is abandoned
   localparam int unsigned STALL_LIMIT  = 400;
   // Tiles to send in total, directed part included
   localparam int unsigned TILE_TARGET  = 950;
   // Tiles per block: every Q, K and V head, HEAD_WIDTH_TILES each
   localparam int unsigned BLOCK_TILES  = (Q_HEADS + 2 * KV_HEADS) * HEAD_WIDTH_TILES;
   localparam int unsigned DRAIN_CYCLES = 8;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic [INDEX_W-1:0]  csr_index = '0;
   logic [ADDR_W-1:0]   csr_write_data = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_restart = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_write_valid;
   logic [1:0]          rsp_target_tensor;
   logic [ADDR_W-1:0]   rsp_target_base;
   logic [OFFSET_W-1:0] rsp_local_offset;
   logic [ADDR_W-1:0]   rsp_dest_page;
   logic                rsp_chunk_end;
   logic                rsp_block_end;
   logic                rsp_all_done;

   qkv_head_tile_address_generator dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_restart       (req_restart),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_valid   (rsp_write_valid),
      .rsp_target_tensor (rsp_target_tensor),
      .rsp_target_base   (rsp_target_base),
      .rsp_local_offset  (rsp_local_offset),
      .rsp_dest_page     (rsp_dest_page),
      .rsp_chunk_end     (rsp_chunk_end),
      .rsp_block_end     (rsp_block_end),
      .rsp_all_done      (rsp_all_done)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Walk predictor: a private copy of the registers and the counters.
   // ------------------------------------------------------------------
   cfg_type             live_regs = '0;
   bit                  reload_due = 1'b1;   // first tile after reset reloads
   phase_type           walk_phase = PHASE_Q;
   logic [HEAD_W-1:0]   walk_head = '0;
   logic [WIDTH_W-1:0]  walk_width = '0;
   logic [OFFSET_W-1:0] walk_offset = '0;
   logic [ADDR_W-1:0]   walk_row_page = '0;
   logic [COUNT_W-1:0]  walk_blocks = '0;
   logic [ROW_W-1:0]    walk_row = '0;
   logic [ADDR_W-1:0]   q_page = '0;
   logic [ADDR_W-1:0]   k_page = '0;
   logic [ADDR_W-1:0]   v_page = '0;

   rsp_type     pending_commands[$];
   int unsigned tiles_sent;
   int unsigned write_words;
   int unsigned done_words;
   int unsigned settings_loaded;
   int unsigned mismatches;
   bit          send_burst;
   bit          rsp_burst;
   int unsigned rsp_hold;

   // Work out the write command for one tile and advance the walk.
   function automatic rsp_type next_write_command(input logic restart);
      rsp_type     cmd;
      int unsigned heads;
      logic        last_w;
      logic        chunk_done;
      logic        block_done;

      // Reload the walk from the registers before this tile
      if (restart || reload_due) begin
         walk_phase  = PHASE_Q;
         walk_head   = '0;
         walk_width  = '0;
         walk_offset = '0;
         walk_blocks = '0;
         walk_row    = live_regs.start_row;
         q_page      = live_regs.q_start_page;
         k_page      = live_regs.k_start_page;
         v_page      = live_regs.v_start_page;
         walk_row_page = q_page;
         reload_due  = 1'b0;
      end

      cmd = '0;
      // Block count is read live, so a lowered count ends the walk at once
      if (walk_blocks >= live_regs.block_count) begin
         cmd.all_done = 1'b1;
         return cmd;
      end

      heads      = (walk_phase == PHASE_Q) ? Q_HEADS : KV_HEADS;
      last_w     = (walk_width + 1 >= HEAD_WIDTH_TILES);
      chunk_done = last_w && (walk_head + 1 >= heads);
      block_done = chunk_done && (walk_phase == PHASE_V);

      cmd.write_valid   = 1'b1;
      cmd.target_tensor = walk_phase;
      case (walk_phase)
         PHASE_Q: cmd.target_base = live_regs.q_base_address;
         PHASE_K: cmd.target_base = live_regs.k_base_address;
         default: cmd.target_base = live_regs.v_base_address;
      endcase
      cmd.local_offset = walk_offset;
      cmd.dest_page    = walk_row_page + ADDR_W'(walk_width);
      cmd.chunk_end    = chunk_done;
      cmd.block_end    = block_done;
      cmd.all_done     = block_done && (walk_blocks + 1 >= live_regs.block_count);

      walk_offset = walk_offset + TILE_STEP;
      walk_width  = walk_width + 1'b1;
      if (last_w) begin
         walk_width    = '0;
         walk_head     = walk_head + 1'b1;
         walk_row_page = walk_row_page + STRIDE_STEP;
      end
      if (chunk_done) begin
         walk_head   = '0;
         walk_offset = '0;
         if (walk_phase == PHASE_V) begin
            walk_phase = PHASE_Q;
            // Step to the next row, or roll over into the next batch
            if (walk_row + 1 < SEQ_TILE_ROWS) begin
               q_page   = q_page + ROW_STEP;
               k_page   = k_page + ROW_STEP;
               v_page   = v_page + ROW_STEP;
               walk_row = walk_row + 1'b1;
            end else begin
               q_page   = q_page + Q_ROLL_STEP;
               k_page   = k_page + KV_ROLL_STEP;
               v_page   = v_page + KV_ROLL_STEP;
               walk_row = '0;
            end
            walk_blocks = walk_blocks + 1'b1;
         end else if (walk_phase == PHASE_Q) begin
            walk_phase = PHASE_K;
         end else begin
            walk_phase = PHASE_V;
         end
         case (walk_phase)
            PHASE_Q: walk_row_page = q_page;
            PHASE_K: walk_row_page = k_page;
            default: walk_row_page = v_page;
         endcase
      end
      return cmd;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Write all eight registers back to back, then drop the write enable.
   // Narrow registers get random upper bits to show they are masked off.
   task automatic write_registers(input cfg_type regs);
      logic [ADDR_W-1:0] data;
      int                idx;
      for (idx = 0; idx < 8; idx++) begin
         data = $urandom;
         case (INDEX_W'(idx))
            CSR_Q_BASE_ADDRESS: data = regs.q_base_address;
            CSR_K_BASE_ADDRESS: data = regs.k_base_address;
            CSR_V_BASE_ADDRESS: data = regs.v_base_address;
            CSR_BLOCK_COUNT:    data[COUNT_W-1:0] = regs.block_count;
            CSR_START_ROW:      data[ROW_W-1:0] = regs.start_row;
            CSR_Q_START_PAGE:   data = regs.q_start_page;
            CSR_K_START_PAGE:   data = regs.k_start_page;
            default:            data = regs.v_start_page;
         endcase
         csr_write_enable <= 1'b1;
         csr_index        <= INDEX_W'(idx);
         csr_write_data   <= data;
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      live_regs = regs;
      settings_loaded++;
   endtask

   // Send one tile word; wait a random gap first unless in a burst.
   task automatic send_tile(input logic restart);
      int unsigned gap;
      if ($urandom_range(0, 31) == 0)
         send_burst = !send_burst;
      gap = send_burst ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_commands.push_back(next_write_command(restart));
      tiles_sent++;
   endtask

   // Drop valid and hold until every expected command has come back.
   task automatic drain_commands();
      req_valid <= 1'b0;
      while (pending_commands.size() != 0) @(posedge clock);
   endtask

   function automatic logic [ADDR_W-1:0] extreme_word();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         2:       return ADDR_W'(32'hFFFF_FFFF - $urandom_range(0, 200));
         default: return ADDR_W'($urandom);
      endcase
   endfunction

   function automatic cfg_type random_regs();
      cfg_type regs;
      regs.q_base_address = extreme_word();
      regs.k_base_address = extreme_word();
      regs.v_base_address = extreme_word();
      regs.q_start_page   = extreme_word();
      regs.k_start_page   = extreme_word();
      regs.v_start_page   = extreme_word();
      // Mostly short runs so the walk reaches its end; sometimes none or very long
      case ($urandom_range(0, 7))
         0:       regs.block_count = '0;
         1:       regs.block_count = '1;
         default: regs.block_count = COUNT_W'($urandom_range(1, 3));
      endcase
      // Favor rows next to the rollover and past the sequence end
      case ($urandom_range(0, 4))
         0:       regs.start_row = '0;
         1:       regs.start_row = ROW_W'(SEQ_TILE_ROWS - 2);
         2:       regs.start_row = ROW_W'(SEQ_TILE_ROWS - 1);
         3:       regs.start_row = '1;
         default: regs.start_row = ROW_W'($urandom_range(0, 1023));
      endcase
      return regs;
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Registers still at reset: a zero block count is done on the first tile,
   // which reloads on its own even without restart.
   task automatic test_power_on();
      send_tile(1'b0);
      send_tile(1'b1);
      drain_commands();
   endtask

   // All-ones bases, the largest count, the largest start row, and Q and K pages
   // near the top of the address space so the Q dest_page wraps within the first head.
   task automatic test_register_extremes();
      cfg_type regs;
      int      n;
      regs.q_base_address = '1;
      regs.k_base_address = '1;
      regs.v_base_address = '1;
      regs.block_count    = '1;
      regs.start_row      = '1;
      regs.q_start_page   = '1;
      regs.k_start_page   = 32'hFFFF_FFF0;
      regs.v_start_page   = '0;
      write_registers(regs);
      for (n = 0; n < 8; n++)
         send_tile(n == 0);
      drain_commands();
   endtask

   // Registers at their lows. A zero count ends the running walk at once;
   // raising it again resumes the old walk until a restart reloads it.
   task automatic test_live_count();
      cfg_type regs;
      int      n;
      regs = '0;
      write_registers(regs);
      send_tile(1'b0);
      drain_commands();
      regs.block_count = 1;
      write_registers(regs);
      send_tile(1'b0);
      for (n = 0; n < 4; n++)
         send_tile(n == 0);
      drain_commands();
   endtask

   // Whole walks with random registers: mostly clean runs through every
   // block to the done words, with stray restarts and mid-walk drains mixed in.
   task automatic test_random_walks();
      cfg_type     regs;
      int unsigned walks;
      int unsigned len;
      int unsigned n;
      logic        first_restart;
      walks = 0;
      while (tiles_sent < TILE_TARGET) begin
         drain_commands();
         regs = random_regs();
         first_restart = ($urandom_range(0, 4) != 0);
         if (walks == 0) begin
            // Open with a walk that rolls over and finishes
            regs.start_row   = ROW_W'(SEQ_TILE_ROWS - 1);
            regs.block_count = 2;
            first_restart    = 1'b1;
         end
         write_registers(regs);
         if (regs.block_count <= 3)
            len = regs.block_count * BLOCK_TILES + $urandom_range(1, 5);
         else
            len = $urandom_range(40, 120);
         // Trim the last walk so the run stays at the tile budget
         if (len > TILE_TARGET - tiles_sent)
            len = TILE_TARGET - tiles_sent;
         for (n = 0; n < len; n++) begin
            send_tile((n == 0) ? first_restart : ($urandom_range(0, 99) == 0));
            if ($urandom_range(0, 199) == 0)
               drain_commands();
         end
         walks++;
      end
      drain_commands();
   endtask

   // ------------------------------------------------------------------
   // Response side: random stall per word, compare each word in order.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_commands
      rsp_type seen;
      rsp_type want;
      if (reset) begin
         rsp_hold   = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_write_valid, rsp_target_tensor, rsp_target_base, rsp_local_offset,
                    rsp_dest_page, rsp_chunk_end, rsp_block_end, rsp_all_done};
            if (pending_commands.size() == 0) begin
               $error("unexpected response word %h", seen);
               mismatches++;
            end else begin
               want = pending_commands[0];
               pending_commands.delete(0);
               if (want.write_valid)
                  write_words++;
               else
                  done_words++;
               if (seen.write_valid !== want.write_valid) begin
                  $error("write_valid: expected %0d, got %0d", want.write_valid,
                         seen.write_valid);
                  mismatches++;
               end
               if (seen.target_tensor !== want.target_tensor) begin
                  $error("target_tensor: expected %0d, got %0d", want.target_tensor,
                         seen.target_tensor);
                  mismatches++;
               end
               if (seen.target_base !== want.target_base) begin
                  $error("target_base: expected %h, got %h", want.target_base,
                         seen.target_base);
                  mismatches++;
               end
               if (seen.local_offset !== want.local_offset) begin
                  $error("local_offset: expected %h, got %h", want.local_offset,
                         seen.local_offset);
                  mismatches++;
               end
               if (seen.dest_page !== want.dest_page) begin
                  $error("dest_page: expected %h, got %h", want.dest_page, seen.dest_page);
                  mismatches++;
               end
               if (seen.chunk_end !== want.chunk_end) begin
                  $error("chunk_end: expected %0d, got %0d", want.chunk_end, seen.chunk_end);
                  mismatches++;
               end
               if (seen.block_end !== want.block_end) begin
                  $error("block_end: expected %0d, got %0d", want.block_end, seen.block_end);
                  mismatches++;
               end
               if (seen.all_done !== want.all_done) begin
                  $error("all_done: expected %0d, got %0d", want.all_done, seen.all_done);
                  mismatches++;
               end
            end
            // Draw the stall ahead of the next word; flip into or out of bursts now and then
            if ($urandom_range(0, 31) == 0)
               rsp_burst = !rsp_burst;
            rsp_hold = rsp_burst ? 0 : $urandom_range(0, 7);
         end else if (rsp_hold != 0) begin
            rsp_hold--;
         end
         rsp_stall <= (rsp_hold != 0);
      end
   end

   // Watchdog: give up when neither channel moves for too long.
   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: no handshake for %0d cycles, %0d commands outstanding",
               STALL_LIMIT, pending_commands.size());
      $display("== FAIL ==");
      $finish;
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_power_on();
      test_register_extremes();
      test_live_count();
      test_random_walks();

      // Hold for DRAIN_CYCLES more to catch any stray word after the last one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_commands.size() != 0) begin
         $error("%0d commands never arrived", pending_commands.size());
         mismatches++;
      end

      $display("Sent %0d tiles over %0d register settings: %0d write commands, %0d done words.",
               tiles_sent, settings_loaded, write_words, done_words);
      $display("Stimulus spanned restarts, live count changes, row rollover and page wrap.");
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
